/* rtl/core/mcs_pkg.sv */
// Shared types, constants and helpers for the max clique search unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcs_pkg;

  // Fixed geometry of the adjacency rows and of the beat fields
  localparam int MCS_ROW_SLOTS    = 32;
  localparam int MCS_MAX_VERTICES = 32;
  localparam int MCS_ROW_W        = 32;
  localparam int MCS_IDX_W        = 5;
  localparam int MCS_VCNT_W       = 6;
  localparam int MCS_LB_W         = 7;
  localparam int MCS_DEG_W        = 6;
  localparam int MCS_BEST_W       = 8;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Lowest reportable clique size (7-bit signed result)
  localparam logic signed [MCS_BEST_W-1:0] SIZE_MIN = -8'sd64;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // write one adjacency row
    logic start;   // initialise a search
    logic step;    // one try or one pop
    logic finish;  // capture the result
  } mcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exhausted;    // candidate has run past the vertex count
    logic stack_empty;  // no vertex on the stack
  } mcs_stat_t;

  // Number of set bits in one row
  function automatic logic [MCS_DEG_W-1:0] row_popcount(input logic [MCS_ROW_W-1:0] row);
    logic [MCS_DEG_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MCS_ROW_W; i++) begin
      cnt = cnt + MCS_DEG_W'(row[i]);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mcs_datapath.sv */
// Datapath of the max clique search unit: row and degree stores, vertex
// stack, search registers and result register. Depends on mcs_pkg.
`default_nettype none

module mcs_datapath
  import mcs_pkg::*;
#(
  parameter int MAX_VERTICES = MCS_MAX_VERTICES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mcs_cmd_t                    cmd,
  output mcs_stat_t                        stat,
  input  wire logic [MCS_IDX_W-1:0]        in_row_index,
  input  wire logic [MCS_ROW_W-1:0]        in_row_bits,
  input  wire logic [MCS_VCNT_W-1:0]       in_vertex_count,
  input  wire logic signed [MCS_LB_W-1:0]  in_lower_bound,
  output logic signed [MCS_LB_W-1:0]       out_max_size,
  output logic                             out_clique_found,
  output logic [MCS_ROW_W-1:0]             out_clique_mask
);

  localparam int ROWS = (MAX_VERTICES < MCS_ROW_SLOTS) ? MAX_VERTICES : MCS_ROW_SLOTS;
  localparam int IW   = $clog2(ROWS);
  localparam int SZW  = IW + 1;

  // Stores (no reset: contents undefined until written)
  logic [MCS_ROW_W-1:0] rows_r  [ROWS];
  logic [MCS_DEG_W-1:0] deg_r   [ROWS];
  logic [IW-1:0]        stack_r [ROWS];

  // Search state
  logic [SZW-1:0]               depth_r, depth_nxt;
  logic [SZW-1:0]               cand_r, cand_nxt;
  logic [SZW-1:0]               n_r, n_nxt;
  logic [SZW-1:0]               size_r, size_nxt;
  logic [MCS_ROW_W-1:0]         clique_r, clique_nxt;
  logic signed [MCS_BEST_W-1:0] best_r, best_nxt;
  logic signed [MCS_BEST_W-1:0] start_r, start_nxt;
  logic [MCS_ROW_W-1:0]         best_clique_r, best_clique_nxt;

  // Result register
  logic signed [MCS_LB_W-1:0]   res_size_r;
  logic                         res_found_r;
  logic [MCS_ROW_W-1:0]         res_mask_r;

  logic [IW-1:0]                cand_idx;
  logic [SZW-1:0]               depth_m1;
  logic [IW-1:0]                top_v;
  logic [MCS_ROW_W-1:0]         row_sel;
  logic [MCS_DEG_W-1:0]         deg_sel;
  logic                         deg_ok;
  logic                         fits;
  logic                         push;
  logic [SZW-1:0]               size_inc;
  logic                         grows;
  logic [MCS_ROW_W-1:0]         cand_bit;
  logic [MCS_ROW_W-1:0]         top_bit;
  logic                         row_ok;
  logic [IW-1:0]                wr_idx;
  logic signed [MCS_BEST_W-1:0] lb_ext;

  // Reads of the stores for the current step
  assign cand_idx = cand_r[IW-1:0];
  assign depth_m1 = depth_r - 1'b1;
  assign top_v    = stack_r[depth_m1[IW-1:0]];
  assign row_sel  = rows_r[cand_idx];
  assign deg_sel  = deg_r[cand_idx];
  assign cand_bit = {1'b1, {(MCS_ROW_W-1){1'b0}}} >> cand_idx;
  assign top_bit  = {1'b1, {(MCS_ROW_W-1){1'b0}}} >> top_v;

  // Admission test for the candidate
  assign deg_ok   = $signed({2'b00, deg_sel}) >= (best_r - 8'sd1);
  assign fits     = (clique_r & ~row_sel) == '0;
  assign push     = deg_ok && fits;
  assign size_inc = size_r + 1'b1;
  assign grows    = $signed({{(MCS_BEST_W-SZW){1'b0}}, size_inc}) > best_r;

  assign stat.exhausted   = cand_r >= n_r;
  assign stat.stack_empty = depth_r == '0;

  // Load address
  assign row_ok = {2'b00, in_row_index} < 7'(MAX_VERTICES);
  assign wr_idx = in_row_index[IW-1:0];
  assign lb_ext = MCS_BEST_W'(in_lower_bound);

  // Next state of the search
  always_comb begin
    depth_nxt       = depth_r;
    cand_nxt        = cand_r;
    n_nxt           = n_r;
    size_nxt        = size_r;
    clique_nxt      = clique_r;
    best_nxt        = best_r;
    start_nxt       = start_r;
    best_clique_nxt = best_clique_r;
    if (cmd.start) begin
      depth_nxt       = '0;
      cand_nxt        = '0;
      size_nxt        = '0;
      clique_nxt      = '0;
      best_clique_nxt = '0;
      best_nxt        = lb_ext - 8'sd1;
      start_nxt       = lb_ext - 8'sd1;
      if (in_vertex_count > MCS_VCNT_W'(ROWS)) begin
        n_nxt = SZW'(ROWS);
      end else begin
        n_nxt = SZW'(in_vertex_count);
      end
    end else if (cmd.step) begin
      if (stat.exhausted) begin
        // backtrack: drop the top vertex, resume after it
        depth_nxt  = depth_m1;
        size_nxt   = size_r - 1'b1;
        clique_nxt = clique_r ^ top_bit;
        cand_nxt   = {1'b0, top_v} + 1'b1;
      end else begin
        cand_nxt = cand_r + 1'b1;
        if (push) begin
          depth_nxt  = depth_r + 1'b1;
          size_nxt   = size_inc;
          clique_nxt = clique_r ^ cand_bit;
          if (grows) begin
            best_nxt        = $signed({{(MCS_BEST_W-SZW){1'b0}}, size_inc});
            best_clique_nxt = clique_r ^ cand_bit;
          end
        end
      end
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r       <= '0;
      cand_r        <= '0;
      n_r           <= '0;
      size_r        <= '0;
      clique_r      <= '0;
      best_r        <= '0;
      start_r       <= '0;
      best_clique_r <= '0;
    end else begin
      depth_r       <= depth_nxt;
      cand_r        <= cand_nxt;
      n_r           <= n_nxt;
      size_r        <= size_nxt;
      clique_r      <= clique_nxt;
      best_r        <= best_nxt;
      start_r       <= start_nxt;
      best_clique_r <= best_clique_nxt;
    end
  end

  // Row, degree and stack stores
  always_ff @(posedge clk) begin
    if (cmd.load && row_ok) begin
      rows_r[wr_idx] <= in_row_bits;
      deg_r[wr_idx]  <= row_popcount(in_row_bits);
    end
    if (cmd.step && !stat.exhausted && push) begin
      stack_r[depth_r[IW-1:0]] <= cand_idx;
    end
  end

  // Result capture, size clamped to the 7-bit signed range
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_found_r <= best_r > start_r;
      res_mask_r  <= (best_r > start_r) ? best_clique_r : '0;
      if (best_r < SIZE_MIN) begin
        res_size_r <= SIZE_MIN[MCS_LB_W-1:0];
      end else begin
        res_size_r <= best_r[MCS_LB_W-1:0];
      end
    end
  end

  assign out_max_size     = res_size_r;
  assign out_clique_found = res_found_r;
  assign out_clique_mask  = res_mask_r;

endmodule

`default_nettype wire

/* rtl/core/mcs_ctrl.sv */
// Controller of the max clique search unit: input and output handshakes
// and the search sequencing. Depends on mcs_pkg.
`default_nettype none

module mcs_ctrl
  import mcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_req_type,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire mcs_stat_t stat,
  output mcs_cmd_t       cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   in_take;
  logic   search_end;

  // A run waits while a result beat is still pending; loads do not
  assign in_stall   = (state_r != ST_IDLE) || (out_valid_r && (in_req_type == REQ_RUN));
  assign in_take    = in_valid && !in_stall;
  assign search_end = stat.exhausted && stat.stack_empty;

  // Commands to the datapath
  assign cmd.load   = in_take && (in_req_type == REQ_LOAD);
  assign cmd.start  = in_take && (in_req_type == REQ_RUN);
  assign cmd.step   = (state_r == ST_SEARCH) && !search_end;
  assign cmd.finish = (state_r == ST_SEARCH) && search_end;

  // State and result-valid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.start) begin
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (search_end) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/max_clique_search_unit.sv */
// Max clique search unit: a load beat writes one adjacency row, one load per cycle
// while no search is running. A run beat starts a backtracking search that makes
// one candidate try or one stack pop per cycle, then captures the result in the
// result register and raises the output beat; runs are taken one at a time.
// Reset (rst_n low, synchronous) clears the controller and search registers;
// row, degree and stack stores are undefined until written.
`default_nettype none

module max_clique_search_unit
  import mcs_pkg::*;
#(
  parameter int MAX_VERTICES = MCS_MAX_VERTICES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [MCS_IDX_W-1:0]        in_row_index,
  input  wire logic [MCS_ROW_W-1:0]        in_row_bits,
  input  wire logic [MCS_VCNT_W-1:0]       in_vertex_count,
  input  wire logic signed [MCS_LB_W-1:0]  in_lower_bound,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [MCS_LB_W-1:0]       out_max_size,
  output logic                             out_clique_found,
  output logic [MCS_ROW_W-1:0]             out_clique_mask
);

  mcs_cmd_t  cmd;
  mcs_stat_t stat;

  mcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  mcs_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .in_vertex_count  (in_vertex_count),
    .in_lower_bound   (in_lower_bound),
    .out_max_size     (out_max_size),
    .out_clique_found (out_clique_found),
    .out_clique_mask  (out_clique_mask)
  );

  // An accepted run keeps the input side busy in the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == REQ_RUN) |=> in_stall)
    else $error("run beat accepted but block not busy");

  // Result capture raises the output beat
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("search finished without a result beat");

  // No clique beyond the bound means an empty mask
  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_clique_found) |-> (out_clique_mask == '0))
    else $error("mask set without a found clique");

  // A reported clique has as many members as its size
  a_mask_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clique_found) |-> ($countones(out_clique_mask) == int'(out_max_size)))
    else $error("clique mask and size disagree");

endmodule

`default_nettype wire

/* sim/max_clique_search_unit_tb.sv */
// Self-checking testbench for max_clique_search_unit: adjacency row loads and
// clique searches, checked beat by beat against a behavioural search predictor.
// Depends on mcs_pkg (widths, request codes) and the RTL of the unit.
`timescale 1ns / 100ps

module max_clique_search_unit_tb;
  import mcs_pkg::*;

  // One input beat, with a typed-in result where the answer is obvious
  typedef struct packed {
    logic                        req;
    logic [MCS_IDX_W-1:0]        idx;
    logic [MCS_ROW_W-1:0]        bits;
    logic [MCS_VCNT_W-1:0]       vcount;
    logic signed [MCS_LB_W-1:0]  lbound;
    logic                        known;
    logic signed [MCS_LB_W-1:0]  k_size;
    logic                        k_found;
    logic [MCS_ROW_W-1:0]        k_mask;
  } stim_row_t;

  // One search result as the unit should return it
  typedef struct packed {
    logic signed [MCS_LB_W-1:0]  size;
    logic                        found;
    logic [MCS_ROW_W-1:0]        mask;
    logic [31:0]                 tag;
  } clique_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_req_type;
  logic [MCS_IDX_W-1:0]        in_row_index;
  logic [MCS_ROW_W-1:0]        in_row_bits;
  logic [MCS_VCNT_W-1:0]       in_vertex_count;
  logic signed [MCS_LB_W-1:0]  in_lower_bound;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [MCS_LB_W-1:0]  out_max_size;
  logic                        out_clique_found;
  logic [MCS_ROW_W-1:0]        out_clique_mask;

  // Predictor copy of the graph
  logic [MCS_ROW_W-1:0]        row_store [MCS_ROW_SLOTS];
  int                          degree_store [MCS_ROW_SLOTS];

  clique_result_t              pending_results [$];
  clique_result_t              want;
  stim_row_t                   directed [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int holds_done = 0;
  int mismatches = 0;
  int loads_done = 0;
  int runs_done = 0;
  int results_seen = 0;
  int found_seen = 0;
  int longest_search = 0;

  max_clique_search_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .in_vertex_count  (in_vertex_count),
    .in_lower_bound   (in_lower_bound),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_max_size     (out_max_size),
    .out_clique_found (out_clique_found),
    .out_clique_mask  (out_clique_mask)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // Backtracking search over vertices 0..n-1 on the predictor's graph.
  // Gives up after step_cap steps; the result is then only good for planning.
  function automatic void search_clique(input logic [MCS_VCNT_W-1:0] vcount,
                                        input logic signed [MCS_LB_W-1:0] lbound,
                                        input int step_cap,
                                        output clique_result_t res,
                                        output int steps);
    int n, start, best, cand, depth, csize, clamped;
    logic [MCS_ROW_W-1:0] cur, best_mask;
    int vstack [MCS_ROW_SLOTS];
    bit done;
    n = (int'(vcount) > MCS_MAX_VERTICES) ? MCS_MAX_VERTICES : int'(vcount);
    start = int'(lbound) - 1;
    best = start;
    cand = 0;
    depth = 0;
    csize = 0;
    cur = '0;
    best_mask = '0;
    steps = 0;
    done = 1'b0;
    while (!done && steps < step_cap) begin
      steps++;
      if (cand >= n) begin
        // candidates used up: pop and resume after the popped vertex
        if (depth == 0) begin
          done = 1'b1;
        end else begin
          depth--;
          cand = vstack[depth];
          csize--;
          cur ^= 32'h8000_0000 >> cand;
          cand++;
        end
      end else begin
        if (degree_store[cand] >= best - 1 && (cur & ~row_store[cand]) == '0) begin
          vstack[depth] = cand;
          depth++;
          csize++;
          cur ^= 32'h8000_0000 >> cand;
          if (csize > best) begin
            best = csize;
            best_mask = cur;
          end
        end
        cand++;
      end
    end
    clamped = (best < -64) ? -64 : (best > 63) ? 63 : best;
    res.size = MCS_LB_W'(clamped);
    res.found = (best > start);
    res.mask = res.found ? best_mask : '0;
    res.tag = '0;
  endfunction

  // Neighbour sets of varying density, 0 sparse .. 4 nearly full
  function automatic logic [MCS_ROW_W-1:0] pick_row(input int style);
    logic [31:0] a, b, c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    case (style)
      0: return a & b & c;
      1: return a & b;
      2: return a;
      3: return a | b;
      default: return a | b | c;
    endcase
  endfunction

  function automatic stim_row_t mk(input logic req, input int idx, input logic [31:0] bits,
                                   input int vc, input int lb, input bit known,
                                   input int ksize, input bit kfound,
                                   input logic [31:0] kmask);
    stim_row_t r;
    r.req = req;
    r.idx = MCS_IDX_W'(idx);
    r.bits = bits;
    r.vcount = MCS_VCNT_W'(vc);
    r.lbound = MCS_LB_W'(lb);
    r.known = known;
    r.k_size = MCS_LB_W'(ksize);
    r.k_found = kfound;
    r.k_mask = kmask;
    return r;
  endfunction

  // Offer one beat, hold it until taken, then update the predictor
  task automatic send_beat(input stim_row_t s);
    clique_result_t res;
    int steps;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= s.req;
    in_row_index    <= s.idx;
    in_row_bits     <= s.bits;
    in_vertex_count <= s.vcount;
    in_lower_bound  <= s.lbound;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (s.req == REQ_LOAD) begin
      row_store[s.idx] = s.bits;
      degree_store[s.idx] = $countones(s.bits);
      loads_done++;
    end else begin
      search_clique(s.vcount, s.lbound, 1 << 30, res, steps);
      if (steps > longest_search) longest_search = steps;
      if (s.known) begin
        res.size = s.k_size;
        res.found = s.k_found;
        res.mask = s.k_mask;
      end
      res.tag = runs_done;
      pending_results.push_back(res);
      runs_done++;
    end
  endtask

  // Sender goes quiet until every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with no search pending (size %0d)",
                                  out_max_size));
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.found) found_seen++;
        if (out_max_size !== want.size)
          report_mismatch($sformatf("run %0d max_size %0d, want %0d",
                                    want.tag, out_max_size, want.size));
        if (out_clique_found !== want.found)
          report_mismatch($sformatf("run %0d clique_found %0b, want %0b",
                                    want.tag, out_clique_found, want.found));
        if (out_clique_mask !== want.mask)
          report_mismatch($sformatf("run %0d clique_mask %08h, want %08h",
                                    want.tag, out_clique_mask, want.mask));
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #400_000_000;
    $display("max_clique_search_unit_tb: errors");
    $finish;
  end

  // Stimulus
  initial begin
    int idle_of [4];
    int stall_of [4];
    int sent, style, nload, budget, nv, steps, lb;
    bit paused;
    stim_row_t s;
    clique_result_t plan;

    idle_of  = '{0, 63, 0, 11};
    stall_of = '{0, 0, 63, 11};
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_LOAD;
    in_row_index    <= '0;
    in_row_bits     <= '0;
    in_vertex_count <= '0;
    in_lower_bound  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every row written before any search reads it
    for (int i = 0; i < MCS_ROW_SLOTS; i++) begin
      send_beat(mk(REQ_LOAD, i, pick_row(0), $urandom, $urandom, 0, 0, 0, 0));
    end

    // directed cases: empty count, bound extremes, isolated vertex,
    // complete subgraph, broken clique, count saturation, alternating rows
    directed.push_back(mk(REQ_RUN,  0, 0,            0,   0, 1, -1,  0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            0, -64, 1, -64, 0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            0,  63, 1, 62,  0, 0));
    directed.push_back(mk(REQ_LOAD, 0, 32'h0,        0,   0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            1,   0, 1, 1,   1, 32'h8000_0000));
    directed.push_back(mk(REQ_RUN,  0, 0,            1,   2, 1, 1,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            1,   3, 1, 2,   0, 0));
    directed.push_back(mk(REQ_LOAD, 0, 32'hFFFF_FFFF, 0,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_LOAD, 1, 32'hFFFF_FFFF, 0,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_LOAD, 2, 32'hFFFF_FFFF, 0,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_LOAD, 3, 32'hFFFF_FFFF, 0,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            4,   0, 1, 4,   1, 32'hF000_0000));
    directed.push_back(mk(REQ_RUN,  0, 0,            4,   5, 1, 4,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            4, -64, 1, 4,   1, 32'hF000_0000));
    directed.push_back(mk(REQ_LOAD, 31, 32'hFFFF_FFFF, 0, 0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_LOAD, 2, 32'h0,        0,   0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            4,   0, 1, 3,   1, 32'hD000_0000));
    directed.push_back(mk(REQ_RUN,  0, 0,            32,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            63,  1, 0, 0,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            33, -1, 0, 0,   0, 0));
    directed.push_back(mk(REQ_LOAD, 5, 32'h5555_5555, 0,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_LOAD, 6, 32'hAAAA_AAAA, 0,  0, 0, 0,   0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            8,  63, 1, 62,  0, 0));
    directed.push_back(mk(REQ_RUN,  0, 0,            16, -1, 0, 0,   0, 0));
    foreach (directed[i]) begin
      send_beat(directed[i]);
    end
    wait_for_results();

    // random part: bursts of row loads each followed by a search
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_of[ph];
      stall_pct = stall_of[ph];
      sent = 0;
      paused = 1'b0;
      while (sent < 330) begin
        style = $urandom_range(4);
        nload = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        for (int j = 0; j < nload; j++) begin
          send_beat(mk(REQ_LOAD, $urandom_range(31), pick_row(style),
                       $urandom, $urandom, 0, 0, 0, 0));
          sent++;
        end

        // mid-phase pressure: long output hold-off, or a full drain
        if (!paused && sent >= 165) begin
          paused = 1'b1;
          if (ph == 2) hold_request = 400;
          if (ph == 1) wait_for_results();
        end

        // search size mostly small; trimmed so one search stays affordable
        case ($urandom_range(9))
          0:       nv = 0;
          1:       nv = $urandom_range(13, 32);
          2:       nv = $urandom_range(33, 63);
          default: nv = $urandom_range(1, 12);
        endcase
        lb = ($urandom_range(4) == 0) ? $signed(7'($urandom)) : $urandom_range(7) - 1;
        budget = ($urandom_range(19) == 0) ? 12000 : 1500;
        search_clique(MCS_VCNT_W'(nv), MCS_LB_W'(lb), budget + 1, plan, steps);
        while (steps > budget && nv > 0) begin
          if (nv > MCS_MAX_VERTICES) nv = MCS_MAX_VERTICES;
          nv = nv - 1 - nv / 4;
          search_clique(MCS_VCNT_W'(nv), MCS_LB_W'(lb), budget + 1, plan, steps);
        end
        s = mk(REQ_RUN, $urandom, $urandom, nv, lb, 0, 0, 0, 0);
        send_beat(s);
        sent++;
      end
      wait_for_results();
    end

    wait_for_results();
    repeat (40) @(posedge clk);

    $display("covered %0d row loads and %0d searches (%0d found a clique above the bound)",
             loads_done, runs_done, found_seen);
    $display("longest search %0d steps, %0d long output hold-off(s), %0d results checked",
             longest_search, holds_done, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("max_clique_search_unit_tb: clean");
    end else begin
      $display("max_clique_search_unit_tb: errors");
    end
    $finish;
  end

endmodule
